[rtl/core/pgm_pkg.sv]
// shared types, constants and state encoding for the path glob matcher
`default_nettype none
package pgm_pkg;

	localparam int PatternMax = 64;
	localparam int TextMax    = 256;
	localparam int PaW        = $clog2(PatternMax);
	localparam int TaW        = $clog2(TextMax);
	localparam int PlW        = $clog2(PatternMax + 1);
	localparam int TlW        = $clog2(TextMax + 1);

	localparam logic [7:0] ChSlash = 8'h2f;
	localparam logic [7:0] ChStar  = 8'h2a;
	localparam logic [7:0] ChQuest = 8'h3f;
	localparam logic [7:0] ChLbr   = 8'h5b;
	localparam logic [7:0] ChBsl   = 8'h5c;
	localparam logic [7:0] ChCaret = 8'h5e;
	localparam logic [7:0] ChBang  = 8'h21;
	localparam logic [7:0] ChRbr   = 8'h5d;
	localparam logic [7:0] ChDash  = 8'h2d;
	localparam logic [7:0] ChDot   = 8'h2e;

	localparam logic OpPattern = 1'b0;
	localparam logic OpText    = 1'b1;

	localparam logic [1:0] StOk      = 2'd0;
	localparam logic [1:0] StPatOvf  = 2'd1;
	localparam logic [1:0] StTextOvf = 2'd2;

	typedef struct packed {
		logic       operation;
		logic [7:0] character;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic       matched;
		logic [1:0] status;
	} out_item_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SCAN,      // look for slash in pattern
		S_PRE,       // decide anchoring
		S_DOT,       // strip ./ pairs
		S_DOT2,
		S_BASE,      // find basename
		S_LOOP,      // main loop head
		S_STAR2,     // after first star
		S_DSTAR,     // after second star
		S_CLS0,      // class: check negation
		S_CLS,       // class element
		S_CLSR,      // class range upper
		S_CLSE,      // class end
		S_ESC,       // escape literal
		S_LIT,       // literal compare
		S_FAIL,      // backtrack
		S_BT1,       // check text at t1
		S_TAIL,      // trailing stars
		S_DONE
	} state_t;

	typedef struct packed {
		logic done;
		logic matched;
	} mres_t;

endpackage
`default_nettype wire

[rtl/core/pgm_ram.sv]
// generic single-port write, single-port registered read ram
`default_nettype none
module pgm_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/core/pgm_engine.sv]
// match sequencer: walks pattern and text stores with backtracking
`default_nettype none
module pgm_engine (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     go,
	input  wire logic [pgm_pkg::PlW-1:0]  plen,
	input  wire logic [pgm_pkg::TlW-1:0]  tlen,
	output logic      [pgm_pkg::PaW-1:0]  praddr,
	input  wire logic [7:0]               prdata,
	output logic      [pgm_pkg::TaW-1:0]  traddr,
	input  wire logic [7:0]               trdata,
	output pgm_pkg::mres_t                res
);
	import pgm_pkg::*;

	// one extra bit so indexes past the end do not wrap
	localparam int GW = PlW + 1;
	localparam int TW = TlW + 1;

	state_t state_q, state_d;
	logic [GW-1:0] g_q, g_d, g1_q, g1_d, g2_q, g2_d, sg_q, sg_d;
	logic [TW-1:0] t_q, t_d, t1_q, t1_d, t2_q, t2_d;
	logic b1_q, b1_d, b2_q, b2_d, slash_q, slash_d;
	logic rev_q, rev_d, hit_q, hit_d, pv_q, pv_d;
	logic [7:0] prev_q, prev_d, lo_q, lo_d, x_q, x_d;
	logic [1:0] ph_q, ph_d;   // read phase: 0 issue address, 1 data valid
	logic [GW-1:0] pa;
	logic [TW-1:0] ta;
	logic [GW-1:0] pa_q;
	logic [TW-1:0] ta_q;
	logic [7:0] pc, tc;
	logic done_d, m_d;

	// addresses are held and data masked to zero past the stored length
	assign praddr = pa[PaW-1:0];
	assign traddr = ta[TaW-1:0];
	assign pc = (pa_q < GW'(plen)) ? prdata : 8'd0;
	assign tc = (ta_q < TW'(tlen)) ? trdata : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= 2'd0;
			res     <= '0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			res     <= '{done: done_d, matched: m_d};
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		g_q <= g_d; g1_q <= g1_d; g2_q <= g2_d; sg_q <= sg_d;
		t_q <= t_d; t1_q <= t1_d; t2_q <= t2_d;
		b1_q <= b1_d; b2_q <= b2_d; slash_q <= slash_d;
		rev_q <= rev_d; hit_q <= hit_d; pv_q <= pv_d;
		prev_q <= prev_d; lo_q <= lo_d; x_q <= x_d;
		pa_q <= pa; ta_q <= ta;
	end

	// sequencer: most states wait for a registered pattern and text byte read before acting;
	// fail and escape advance without waiting for read data
	always_comb begin
		logic rdy;
		state_d = state_q; ph_d = ph_q;
		g_d = g_q; g1_d = g1_q; g2_d = g2_q; sg_d = sg_q;
		t_d = t_q; t1_d = t1_q; t2_d = t2_q;
		b1_d = b1_q; b2_d = b2_q; slash_d = slash_q;
		rev_d = rev_q; hit_d = hit_q; pv_d = pv_q;
		prev_d = prev_q; lo_d = lo_q; x_d = x_q;
		done_d = 1'b0; m_d = 1'b0;
		pa = pa_q; ta = ta_q;
		rdy = (ph_q == 2'd1);
		case (state_q)
			S_IDLE: pa = '0;
			S_SCAN: pa = sg_q;
			S_DOT, S_DOT2: begin pa = '0; ta = t_q; end
			S_BASE: ta = t1_q;
			S_BT1: ta = t1_q;
			default: begin pa = g_q; ta = t_q; end
		endcase
		if (state_q != S_IDLE && state_q != S_DONE) begin
			ph_d = rdy ? 2'd0 : 2'd1;
		end
		case (state_q)
			S_IDLE: begin
				if (go) begin
					sg_d = '0; slash_d = 1'b0; ph_d = 2'd0;
					state_d = S_SCAN;
				end
			end
			S_SCAN: if (rdy) begin
				if (sg_q >= GW'(plen)) begin
					state_d = S_PRE; g_d = '0; t_d = '0;
				end else begin
					if (pc == ChSlash) slash_d = 1'b1;
					sg_d = sg_q + 1'b1;
				end
			end
			S_PRE: if (rdy) begin
				b1_d = 1'b0; b2_d = 1'b0;
				if (pc == ChSlash) begin
					g_d = GW'(1); state_d = S_DOT;
				end else if (!slash_q) begin
					t1_d = '0; state_d = S_BASE;
				end else state_d = S_LOOP;
			end
			S_DOT: if (rdy) begin
				if (tc == ChDot) begin t_d = t_q + 1'b1; state_d = S_DOT2; end
				else begin
					if (tc == ChSlash) t_d = t_q + 1'b1;
					state_d = S_LOOP;
				end
			end
			S_DOT2: if (rdy) begin
				if (tc == ChSlash) begin t_d = t_q + 1'b1; state_d = S_DOT; end
				else begin t_d = t_q - 1'b1; state_d = S_LOOP; end
			end
			S_BASE: if (rdy) begin
				if (t1_q >= TW'(tlen)) state_d = S_LOOP;
				else begin
					if (tc == ChSlash) t_d = t1_q + 1'b1;
					t1_d = t1_q + 1'b1;
				end
			end
			S_LOOP: if (rdy) begin
				x_d = tc;
				if (t_q >= TW'(tlen)) state_d = S_TAIL;
				else if (pc == ChStar) begin g_d = g_q + 1'b1; state_d = S_STAR2; end
				else if (pc == ChQuest) begin
					if (tc != ChSlash) begin t_d = t_q + 1'b1; g_d = g_q + 1'b1; end
					else state_d = S_FAIL;
				end else if (pc == ChLbr) begin
					if (tc == ChSlash) state_d = S_FAIL;
					else begin
						g_d = g_q + 1'b1; hit_d = 1'b0; pv_d = 1'b0;
						state_d = S_CLS0;
					end
				end else if (pc == ChBsl) begin
					g_d = g_q + 1'b1; state_d = S_ESC;
				end else if (pc == tc) begin
					t_d = t_q + 1'b1; g_d = g_q + 1'b1;
				end else state_d = S_FAIL;
			end
			S_STAR2: if (rdy) begin
				if (pc == ChStar) begin g_d = g_q + 1'b1; state_d = S_DSTAR; end
				else begin
					t1_d = t_q; g1_d = g_q; b1_d = 1'b1; state_d = S_LOOP;
				end
			end
			S_DSTAR: if (rdy) begin
				if (g_q >= GW'(plen)) begin done_d = 1'b1; m_d = 1'b1; state_d = S_DONE; end
				else if (pc != ChSlash) begin done_d = 1'b1; state_d = S_DONE; end
				else begin
					b1_d = 1'b0; g_d = g_q + 1'b1; t2_d = t_q;
					g2_d = g_q + 1'b1; b2_d = 1'b1; state_d = S_LOOP;
				end
			end
			S_ESC: state_d = S_LIT;
			S_LIT: if (rdy) begin
				if (pc == x_q) begin t_d = t_q + 1'b1; g_d = g_q + 1'b1; state_d = S_LOOP; end
				else state_d = S_FAIL;
			end
			S_CLS0: if (rdy) begin
				// g points at byte after '['
				rev_d = (pc == ChCaret) || (pc == ChBang);
				if (rev_d) g_d = g_q + 1'b1;
				state_d = S_CLS;
			end
			S_CLS: if (rdy) begin
				if (pc == 8'd0 || pc == ChRbr) state_d = S_CLSE;
				else if (pv_q && pc == ChDash) begin
					lo_d = prev_q; g_d = g_q + 1'b1; state_d = S_CLSR;
				end else begin
					if (x_q == pc) hit_d = 1'b1;
					prev_d = pc; pv_d = 1'b1; g_d = g_q + 1'b1;
				end
			end
			S_CLSR: if (rdy) begin
				// g at byte after '-'
				if (pc == 8'd0 || pc == ChRbr) begin
					// dash was literal, element then ends class
					if (x_q == ChDash) hit_d = 1'b1;
					prev_d = ChDash; state_d = S_CLSE;
				end else begin
					if (x_q <= pc && x_q >= lo_q) hit_d = 1'b1;
					prev_d = pc; g_d = g_q + 1'b1; state_d = S_CLS;
				end
			end
			S_CLSE: if (rdy) begin
				if (hit_q != rev_q) begin
					t_d = t_q + 1'b1;
					if (pc != 8'd0) g_d = g_q + 1'b1;
					state_d = S_LOOP;
				end else state_d = S_FAIL;
			end
			S_FAIL: begin
				if (b1_q) state_d = S_BT1;
				else if (b2_q) begin
					t2_d = t2_q + 1'b1; t_d = t2_q + 1'b1; g_d = g2_q; state_d = S_LOOP;
				end else begin done_d = 1'b1; state_d = S_DONE; end
				ph_d = 2'd0;
			end
			S_BT1: if (rdy) begin
				if (tc != ChSlash) begin
					t1_d = t1_q + 1'b1; t_d = t1_q + 1'b1; g_d = g1_q; state_d = S_LOOP;
				end else if (b2_q) begin
					t2_d = t2_q + 1'b1; t_d = t2_q + 1'b1; g_d = g2_q; state_d = S_LOOP;
				end else begin done_d = 1'b1; state_d = S_DONE; end
			end
			S_TAIL: if (rdy) begin
				if (pc == ChStar) g_d = g_q + 1'b1;
				else begin done_d = 1'b1; m_d = (g_q >= GW'(plen)); state_d = S_DONE; end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

[rtl/core/path_glob_matcher.sv]
// top level: character loading, stores and result output
`default_nettype none
// Glob matcher. Pattern and text bytes load one per cycle (busy stays low).
// The text item with last set starts a match unless a store overflowed:
// busy rises and the block walks the pattern and text memories with one
// shared compare sequencer, each step waiting for a registered memory read,
// with backtracking for stars; the number of steps can grow as text length
// times pattern length with backtracking. The result appears for one cycle
// with done high; the receiver cannot stall it. Overflow results come in the
// cycle after the last item, with no match run.
module path_glob_matcher (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire pgm_pkg::in_item_t  in_item,
	output logic                    busy,
	output logic                    done,
	output pgm_pkg::out_item_t      result
);
	import pgm_pkg::*;

	logic [PlW-1:0] plen_q;
	logic [TlW-1:0] tlen_q;
	logic pcomp_q, povf_q, tovf_q, run_q, ovf_res_q;
	logic [1:0] ost_q;
	logic acc, pw, tw;
	logic [PlW-1:0] pbase;
	logic [PaW-1:0] praddr;
	logic [TaW-1:0] traddr;
	logic [7:0] prdata, trdata;
	mres_t eres;
	logic go;

	assign acc = start && !busy;
	assign busy = run_q;
	assign pbase = pcomp_q ? '0 : plen_q;
	assign pw = acc && in_item.operation == OpPattern && in_item.character != 8'd0
		&& pbase < PlW'(PatternMax);
	assign tw = acc && in_item.operation == OpText && in_item.character != 8'd0
		&& tlen_q < TlW'(TextMax);
	assign go = acc && in_item.operation == OpText && in_item.last
		&& !povf_q && !(tovf_q || (in_item.character != 8'd0 && !tw));

	// store bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0; tlen_q <= '0; pcomp_q <= 1'b1;
			povf_q <= 1'b0; tovf_q <= 1'b0; run_q <= 1'b0; ovf_res_q <= 1'b0;
			ost_q <= StOk;
		end else begin
			ovf_res_q <= 1'b0;
			if (acc && in_item.operation == OpPattern) begin
				plen_q <= pw ? pbase + 1'b1 : pbase;
				povf_q <= (pcomp_q ? 1'b0 : povf_q)
					|| (in_item.character != 8'd0 && !pw);
				pcomp_q <= in_item.last;
			end else if (acc) begin
				if (in_item.last) begin
					tlen_q <= tw ? tlen_q + 1'b1 : tlen_q;
					tovf_q <= 1'b0;
					if (!go) begin
						ovf_res_q <= 1'b1;
						ost_q <= povf_q ? StPatOvf : StTextOvf;
					end else run_q <= 1'b1;
				end else begin
					if (tw) tlen_q <= tlen_q + 1'b1;
					if (in_item.character != 8'd0 && !tw) tovf_q <= 1'b1;
				end
			end
			if (eres.done) begin
				run_q <= 1'b0; tlen_q <= '0;
			end
			if (!go && acc && in_item.operation == OpText && in_item.last) tlen_q <= '0;
		end
	end

	// result output
	always_comb begin
		done = ovf_res_q || eres.done;
		result.matched = eres.done && eres.matched;
		result.status = ovf_res_q ? ost_q : StOk;
	end

	pgm_ram #(.Width(8), .Depth(PatternMax)) u_pram (
		.clk(clk), .we(pw), .waddr(pbase[PaW-1:0]), .wdata(in_item.character),
		.raddr(praddr), .rdata(prdata)
	);

	pgm_ram #(.Width(8), .Depth(TextMax)) u_tram (
		.clk(clk), .we(tw), .waddr(tlen_q[TaW-1:0]), .wdata(in_item.character),
		.raddr(traddr), .rdata(trdata)
	);

	pgm_engine u_eng (
		.clk(clk), .arst_n(arst_n), .go(go), .plen(plen_q), .tlen(tlen_q),
		.praddr(praddr), .prdata(prdata), .traddr(traddr), .trdata(trdata),
		.res(eres)
	);
endmodule
`default_nettype wire
